// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rpc3_pkg.sv =====
// Shared constants, widths and types of the three-axis rate PI controller.
package rpc3_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    localparam int GAIN_W     = 31;
    localparam int PERIOD_W   = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int ERR_W   = DATA_WIDTH + 1;
    localparam int INT_W   = GAIN_W + 1;
    localparam int MUL_A_W = (ERR_W > INT_W) ? ERR_W : INT_W;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W - FRAC_BITS + 1;

    localparam logic [GAIN_W-1:0]   RST_GAIN_P_XY = GAIN_W'(1218970);
    localparam logic [GAIN_W-1:0]   RST_GAIN_P_Z  = GAIN_W'(734003);
    localparam logic [GAIN_W-1:0]   RST_GAIN_I_XY = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]   RST_GAIN_I_Z  = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]   RST_BOUND_X   = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]   RST_BOUND_Y   = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]   RST_BOUND_Z   = GAIN_W'(0);
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = PERIOD_W'(66);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_XY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_Z  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_XY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_Z  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_X   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_Y   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_Z   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = CFG_IDX_W'(7);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MDT,
        S_INT,
        S_CLP,
        S_MKI,
        S_SUM
    } t_state;

endpackage

// ===== rtl/rate_pi_controller_3axis_core.sv =====
// Three-axis angular-rate PI controller around one shared multiplier.
// One request at a time: a new one is accepted only once the sequencer is idle,
//   set by the single multiplier and the five-step per-axis sequence (period,
//   integrate, clamp with kp, ki, sum) run for x, y, z; the z sum waits for output.
// Reset (synchronous, active low): integrals cleared, gains, bounds and period
//   to their defaults, sequencer idle, no result pending.
`include "assert_macros.svh"

module rate_pi_controller_3axis_core
    import rpc3_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // input request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_measured_x,
    input  logic signed [DATA_WIDTH-1:0] i_measured_y,
    input  logic signed [DATA_WIDTH-1:0] i_measured_z,
    input  logic signed [DATA_WIDTH-1:0] i_target_x,
    input  logic signed [DATA_WIDTH-1:0] i_target_y,
    input  logic signed [DATA_WIDTH-1:0] i_target_z,
    input  logic signed [DATA_WIDTH-1:0] i_thrust_in,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_command_x,
    output logic signed [DATA_WIDTH-1:0] o_command_y,
    output logic signed [DATA_WIDTH-1:0] o_command_z,
    output logic signed [DATA_WIDTH-1:0] o_thrust_out
);

    // Saturation limits of the command, at accumulator width.
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [GAIN_W-1:0]   r_gain_p_xy, r_gain_p_z, r_gain_i_xy, r_gain_i_z;
    logic [GAIN_W-1:0]   r_bound [3];
    logic [PERIOD_W-1:0] r_period;

    // ---------------------------------------------------------------------
    // Sequencer and datapath state
    // ---------------------------------------------------------------------
    t_state r_state, n_state;
    logic [1:0] r_axis;

    logic signed [ERR_W-1:0]      r_err   [3];   // target - measured, exact
    logic signed [INT_W-1:0]      r_integ [3];   // clamped integrals
    logic signed [PROD_W-1:0]     r_prod;        // shared multiplier output
    logic signed [ACC_W-1:0]      r_acc;         // integral sum / kp term
    logic signed [DATA_WIDTH-1:0] r_cmd   [2];   // x and y commands held for output
    logic signed [DATA_WIDTH-1:0] r_thrust;

    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_cmd_x, r_cmd_y, r_cmd_z, r_thrust_out;

    // ---------------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------------
    logic                      in_acc, out_free, is_z, last_axis;
    logic                      prod_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [GAIN_W-1:0]  mul_b_u;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   p_shift, integ_ext, bnd, neg_bnd, sum, sat;
    logic signed [INT_W-1:0]   clamped;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign is_z      = (r_axis == AXIS_Z);
    assign last_axis = is_z;

    // floor(product / 2^FRAC_BITS): arithmetic shift rounds toward minus infinity
    assign p_shift   = ACC_W'(r_prod >>> FRAC_BITS);
    assign integ_ext = ACC_W'(r_integ[r_axis]);
    assign bnd       = signed'(ACC_W'(r_bound[r_axis]));
    assign neg_bnd   = -bnd;
    assign sum       = r_acc + p_shift;

    always_comb begin
        if (r_acc > bnd) begin
            clamped = INT_W'(bnd);
        end else if (r_acc < neg_bnd) begin
            clamped = INT_W'(neg_bnd);
        end else begin
            clamped = INT_W'(r_acc);
        end
    end

    always_comb begin
        if (sum > SAT_HI) begin
            sat = SAT_HI;
        end else if (sum < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = sum;
        end
    end

    // ---------------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MDT;
                end
            end
            S_MDT: n_state = S_INT;
            S_INT: n_state = S_CLP;
            S_CLP: n_state = S_MKI;
            S_MKI: n_state = S_SUM;
            S_SUM: begin
                if (!last_axis) begin
                    n_state = S_MDT;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer outputs: handshakes and multiplier operand select
    // ---------------------------------------------------------------------
    always_comb begin
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        prod_en     = 1'b0;
        mul_a       = MUL_A_W'(r_err[r_axis]);
        mul_b_u     = is_z ? r_gain_p_z : r_gain_p_xy;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cfg_ready = 1'b1;
            end
            S_MDT: begin
                prod_en = 1'b1;
                mul_b_u = GAIN_W'(r_period);
            end
            S_CLP: begin
                // kp * error, independent of the clamp done alongside
                prod_en = 1'b1;
            end
            S_MKI: begin
                // integral was written at the end of the clamp step
                prod_en = 1'b1;
                mul_a   = MUL_A_W'(r_integ[r_axis]);
                mul_b_u = is_z ? r_gain_i_z : r_gain_i_xy;
            end
            S_INT, S_SUM: begin
            end
            default: begin
            end
        endcase
    end

    assign mul_b = signed'({1'b0, mul_b_u});

    // ---------------------------------------------------------------------
    // Configuration write port
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p_xy <= RST_GAIN_P_XY;
            r_gain_p_z  <= RST_GAIN_P_Z;
            r_gain_i_xy <= RST_GAIN_I_XY;
            r_gain_i_z  <= RST_GAIN_I_Z;
            r_bound[0]  <= RST_BOUND_X;
            r_bound[1]  <= RST_BOUND_Y;
            r_bound[2]  <= RST_BOUND_Z;
            r_period    <= RST_PERIOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_GAIN_P_XY: r_gain_p_xy <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_P_Z:  r_gain_p_z  <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I_XY: r_gain_i_xy <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I_Z:  r_gain_i_z  <= i_cfg_data[GAIN_W-1:0];
                REG_BOUND_X:   r_bound[0]  <= i_cfg_data[GAIN_W-1:0];
                REG_BOUND_Y:   r_bound[1]  <= i_cfg_data[GAIN_W-1:0];
                REG_BOUND_Z:   r_bound[2]  <= i_cfg_data[GAIN_W-1:0];
                REG_PERIOD:    r_period    <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                    // indexes past the register list are dropped
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_out_valid <= 1'b0;
            r_integ[0]  <= '0;
            r_integ[1]  <= '0;
            r_integ[2]  <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_axis <= AXIS_X;
            end else if (r_state == S_SUM && !last_axis) begin
                r_axis <= r_axis + 2'd1;
            end
            if (r_state == S_CLP) begin
                r_integ[r_axis] <= clamped;
            end
            if (r_state == S_SUM && last_axis && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            // all three errors at once: three independent subtractors
            r_err[0] <= ERR_W'(i_target_x) - ERR_W'(i_measured_x);
            r_err[1] <= ERR_W'(i_target_y) - ERR_W'(i_measured_y);
            r_err[2] <= ERR_W'(i_target_z) - ERR_W'(i_measured_z);
            r_thrust <= i_thrust_in;
        end
        if (prod_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (r_state)
            S_INT: r_acc <= integ_ext + p_shift;   // integral + dt * error
            S_MKI: r_acc <= p_shift;               // kp * error term
            default: begin
            end
        endcase
        if (r_state == S_SUM) begin
            if (!last_axis) begin
                r_cmd[r_axis[0]] <= DATA_WIDTH'(sat);
            end else if (out_free) begin
                r_cmd_x      <= r_cmd[0];
                r_cmd_y      <= r_cmd[1];
                r_cmd_z      <= DATA_WIDTH'(sat);
                r_thrust_out <= r_thrust;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_command_x  = r_cmd_x;
    assign o_command_y  = r_cmd_y;
    assign o_command_z  = r_cmd_z;
    assign o_thrust_out = r_thrust_out;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // an accepted request starts the x-axis period product next cycle
    `ASSERT_NEXT(a_start_x, i_clk, i_rst_n, in_acc, (r_state == S_MDT) && (r_axis == AXIS_X))
    // the integral just written never exceeds its bound
    `ASSERT_IMPLIES(a_integ_bound, i_clk, i_rst_n, r_state == S_MKI, (integ_ext <= bnd) && (integ_ext >= neg_bnd))
    // a result appears only after the z-axis sum step
    `ASSERT_IMPLIES(a_out_after_z, i_clk, i_rst_n, $rose(r_out_valid), ($past(r_state) == S_SUM) && ($past(r_axis) == AXIS_Z))

endmodule
